/* rtl/core/crc16_byte_stuffing_framer_macros.svh */
// assertion macros for the crc16 byte stuffing framer checker
// expects signals clk and arst_n in the scope of each use
`ifndef CRC16_BYTE_STUFFING_FRAMER_MACROS_SVH
`define CRC16_BYTE_STUFFING_FRAMER_MACROS_SVH

// same-cycle implication
`define CRCF_ASSERT_IMPL(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("framer check failed");

// next-cycle implication
`define CRCF_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("framer check failed");

`endif

/* rtl/core/crcf_pkg.sv */
// shared types and constants of the crc16 byte stuffing framer
// no dependencies
package crcf_pkg;

	localparam int MAX_PAYLOAD_DEF = 8;

	localparam logic [15:0] CRC_POLY = 16'hFFF1;

	// configuration register indexes
	localparam logic [1:0] CFG_SRC_ADDR = 2'd0;
	localparam logic [1:0] CFG_FLAG     = 2'd1;
	localparam logic [1:0] CFG_ESCAPE   = 2'd2;

	localparam logic [7:0] SRC_ADDR_RESET = 8'd0;
	localparam logic [7:0] FLAG_RESET     = 8'd126;
	localparam logic [7:0] ESCAPE_RESET   = 8'd125;

	// queue between front and back
	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_AW    = 2;

	typedef struct packed {
		logic [7:0] src_addr;
		logic [7:0] flag;
		logic [7:0] escape;
	} crcf_cfg_t;

	typedef struct packed {
		logic [3:0] frame_length;
		logic [7:0] frame_index;
		logic [7:0] frame_count;
		logic [7:0] dst_addr;
		logic       start_of_frame;
		logic [7:0] payload_byte;
	} crcf_item_t;

	// one line byte before stuffing
	typedef struct packed {
		logic [7:0] data;
		logic       stuff;
		logic       frame_end;
		logic       run_last;
	} crcf_entry_t;

endpackage

/* rtl/core/crc16_byte_stuffing_framer.sv */
// top level of the crc16 byte stuffing framer: configuration registers and
// the front, queue and back parts; depends on crcf_pkg and the crcf_* modules
//
// usage:
//  s_axis carries one payload byte per transfer; tuser high marks the first
//  byte of a frame and then the header fields in tdata are taken.
//  m_axis gives one line byte per transfer: opening flag, stuffed header
//  (count, index, source address, destination, length), stuffed payload,
//  stuffed crc-16 high then low byte, closing flag. tuser marks the closing
//  flag, tlast the last byte caused by an input transfer.
//  cfg writes source address (0), flag (1) and escape (2); cfg_ready is high.
// path: an item passes the front sequencer, the queue, the hold register and
//  the output register. throughput: one line byte per cycle from the output
//  register while the receiver takes bytes; an escaped byte goes out as the
//  escape byte and then the byte itself. The front sequencer produces one
//  byte per cycle while the queue has room, and the escape insertion in the
//  back part sets the rate.
// reset: config returns to its defaults, the queue empties, no frame is open.
// stall: the output register holds; the four-entry queue fills, then
//  s_axis_tready drops until the receiver takes bytes again.
module crc16_byte_stuffing_framer import crcf_pkg::*; #(
	parameter int MAX_PAYLOAD = MAX_PAYLOAD_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// payload_byte, dst_addr, frame_count, frame_index, frame_length, zero fill
	input  logic [39:0] s_axis_tdata,
	// start_of_frame
	input  logic        s_axis_tuser,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// line_byte
	output logic [7:0]  m_axis_tdata,
	// frame_end
	output logic        m_axis_tuser,
	// run_last
	output logic        m_axis_tlast,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [7:0]  cfg_data
);

	crcf_cfg_t   cfg_q;
	crcf_item_t  item;
	logic        push_valid;
	logic        push_ready;
	crcf_entry_t push_entry;
	logic        pop_valid;
	logic        pop_ready;
	crcf_entry_t pop_entry;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.src_addr <= SRC_ADDR_RESET;
			cfg_q.flag <= FLAG_RESET;
			cfg_q.escape <= ESCAPE_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_SRC_ADDR: cfg_q.src_addr <= cfg_data;
				CFG_FLAG:     cfg_q.flag <= cfg_data;
				CFG_ESCAPE:   cfg_q.escape <= cfg_data;
				default:      cfg_q <= cfg_q;
			endcase
		end
	end

	always_comb begin
		item.payload_byte   = s_axis_tdata[7:0];
		item.dst_addr       = s_axis_tdata[15:8];
		item.frame_count    = s_axis_tdata[23:16];
		item.frame_index    = s_axis_tdata[31:24];
		item.frame_length   = s_axis_tdata[35:32];
		item.start_of_frame = s_axis_tuser;
	end

	crcf_front #(
		.MAX_PAYLOAD(MAX_PAYLOAD)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg_q),
		.in_valid(s_axis_tvalid),
		.in_ready(s_axis_tready),
		.in_item(item),
		.push_valid(push_valid),
		.push_ready(push_ready),
		.push_entry(push_entry)
	);

	crcf_fifo u_fifo (
		.clk(clk),
		.arst_n(arst_n),
		.push_valid(push_valid),
		.push_ready(push_ready),
		.push_entry(push_entry),
		.pop_valid(pop_valid),
		.pop_ready(pop_ready),
		.pop_entry(pop_entry)
	);

	crcf_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg_q),
		.pop_valid(pop_valid),
		.pop_ready(pop_ready),
		.pop_entry(pop_entry),
		.out_valid(m_axis_tvalid),
		.out_ready(m_axis_tready),
		.out_byte(m_axis_tdata),
		.out_end(m_axis_tuser),
		.out_last(m_axis_tlast)
	);

endmodule

/* rtl/core/crcf_front.sv */
// front part: accepts input items, sequences header, payload, crc and flags,
// and runs the crc; depends on crcf_pkg
module crcf_front import crcf_pkg::*; #(
	parameter int MAX_PAYLOAD = MAX_PAYLOAD_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  crcf_cfg_t   cfg,
	input  logic        in_valid,
	output logic        in_ready,
	input  crcf_item_t  in_item,
	output logic        push_valid,
	input  logic        push_ready,
	output crcf_entry_t push_entry
);

	localparam logic [7:0] MAX_LEN = 8'(MAX_PAYLOAD);

	localparam logic [3:0] ST_FLAG = 4'd0;
	localparam logic [3:0] ST_CNT  = 4'd1;
	localparam logic [3:0] ST_IDX  = 4'd2;
	localparam logic [3:0] ST_MAC  = 4'd3;
	localparam logic [3:0] ST_DEST = 4'd4;
	localparam logic [3:0] ST_LEN  = 4'd5;
	localparam logic [3:0] ST_PAY  = 4'd6;
	localparam logic [3:0] ST_CRCH = 4'd7;
	localparam logic [3:0] ST_CRCL = 4'd8;
	localparam logic [3:0] ST_END  = 4'd9;

	function automatic logic [15:0] crc_feed(input logic [15:0] c, input logic [7:0] b);
		logic [15:0] r;
		r = c ^ {b, 8'h00};
		for (int k = 0; k < 8; k++) begin
			r = r[15] ? ((r << 1) ^ CRC_POLY) : (r << 1);
		end
		return r;
	endfunction

	logic        busy_q;
	logic [3:0]  step_q;
	logic [15:0] crc_q;
	logic [3:0]  rem_q;
	logic        in_frame_q;

	logic [7:0]  pay_q;
	logic [7:0]  dest_q;
	logic [7:0]  cnt_q;
	logic [7:0]  idx_q;
	logic [3:0]  len_q;

	logic        feed;
	logic        last_step;
	logic        fire;
	logic        accept;
	logic        in_frame_eff;
	logic [3:0]  len_clamped;

	always_comb begin
		push_entry = '0;
		feed = 1'b0;
		case (step_q)
			ST_FLAG: begin
				push_entry.data = cfg.flag;
			end
			ST_CNT: begin
				push_entry.data = cnt_q;
				push_entry.stuff = 1'b1;
				feed = 1'b1;
			end
			ST_IDX: begin
				push_entry.data = idx_q;
				push_entry.stuff = 1'b1;
				feed = 1'b1;
			end
			ST_MAC: begin
				push_entry.data = cfg.src_addr;
				push_entry.stuff = 1'b1;
				feed = 1'b1;
			end
			ST_DEST: begin
				push_entry.data = dest_q;
				push_entry.stuff = 1'b1;
				feed = 1'b1;
			end
			ST_LEN: begin
				push_entry.data = {4'b0, len_q};
				push_entry.stuff = 1'b1;
				feed = 1'b1;
			end
			ST_PAY: begin
				push_entry.data = pay_q;
				push_entry.stuff = 1'b1;
				feed = 1'b1;
			end
			ST_CRCH: begin
				push_entry.data = crc_q[15:8];
				push_entry.stuff = 1'b1;
			end
			ST_CRCL: begin
				push_entry.data = crc_q[7:0];
				push_entry.stuff = 1'b1;
			end
			ST_END: begin
				push_entry.data = cfg.flag;
				push_entry.frame_end = 1'b1;
			end
			default: begin
				push_entry = '0;
			end
		endcase
		// an item ends on its payload byte unless that byte closes the frame
		last_step = (step_q == ST_PAY && rem_q != 4'd1) || step_q == ST_END;
		push_entry.run_last = last_step;
	end

	assign push_valid = busy_q;
	assign fire       = busy_q && push_ready;
	assign in_ready   = !busy_q || (fire && last_step);
	assign accept     = in_valid && in_ready;

	// a frame closing in this cycle no longer counts as open
	assign in_frame_eff = in_frame_q && !(busy_q && step_q == ST_END);

	always_comb begin
		if (in_item.frame_length == 4'd0) begin
			len_clamped = 4'd1;
		end else if ({4'b0, in_item.frame_length} > MAX_LEN) begin
			len_clamped = MAX_LEN[3:0];
		end else begin
			len_clamped = in_item.frame_length;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			step_q <= ST_FLAG;
			crc_q <= '0;
			rem_q <= '0;
			in_frame_q <= 1'b0;
		end else begin
			if (fire) begin
				if (feed) begin
					crc_q <= crc_feed(crc_q, push_entry.data);
				end
				if (step_q == ST_PAY) begin
					rem_q <= rem_q - 4'd1;
				end
				if (step_q == ST_END) begin
					in_frame_q <= 1'b0;
				end
				if (last_step) begin
					busy_q <= 1'b0;
				end else begin
					step_q <= step_q + 4'd1;
				end
			end
			if (accept) begin
				if (in_item.start_of_frame) begin
					busy_q <= 1'b1;
					step_q <= ST_FLAG;
					crc_q <= '0;
					rem_q <= len_clamped;
					in_frame_q <= 1'b1;
				end else if (in_frame_eff) begin
					busy_q <= 1'b1;
					step_q <= ST_PAY;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			pay_q <= in_item.payload_byte;
			dest_q <= in_item.dst_addr;
			cnt_q <= in_item.frame_count;
			idx_q <= in_item.frame_index;
			len_q <= len_clamped;
		end
	end

endmodule

/* rtl/core/crcf_fifo.sv */
// short queue of line entries between front and back
// depends on crcf_pkg
module crcf_fifo import crcf_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push_valid,
	output logic        push_ready,
	input  crcf_entry_t push_entry,
	output logic        pop_valid,
	input  logic        pop_ready,
	output crcf_entry_t pop_entry
);

	crcf_entry_t            mem_q [FIFO_DEPTH];
	logic [FIFO_AW-1:0]     wr_ptr_q;
	logic [FIFO_AW-1:0]     rd_ptr_q;
	logic [FIFO_AW:0]       count_q;
	logic                   do_push;
	logic                   do_pop;

	assign push_ready = count_q != (FIFO_AW+1)'(FIFO_DEPTH);
	assign pop_valid  = count_q != '0;
	assign pop_entry  = mem_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

/* rtl/core/crcf_back.sv */
// back part: inserts escape bytes and drives the registered output stream
// depends on crcf_pkg
module crcf_back import crcf_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  crcf_cfg_t   cfg,
	input  logic        pop_valid,
	output logic        pop_ready,
	input  crcf_entry_t pop_entry,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [7:0]  out_byte,
	output logic        out_end,
	output logic        out_last
);

	logic        hold_valid_q;
	crcf_entry_t hold_q;
	logic        esc_done_q;
	logic        m_valid_q;
	logic [7:0]  m_byte_q;
	logic        m_end_q;
	logic        m_last_q;

	logic        out_free;
	logic        need_esc;
	logic        emit;
	logic        finish;

	assign out_free = !m_valid_q || out_ready;
	assign need_esc = hold_q.stuff && !esc_done_q
		&& (hold_q.data == cfg.flag || hold_q.data == cfg.escape);
	assign emit      = hold_valid_q && out_free;
	assign finish    = emit && !need_esc;
	assign pop_ready = !hold_valid_q || finish;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_valid_q <= 1'b0;
			hold_q <= '0;
			esc_done_q <= 1'b0;
			m_valid_q <= 1'b0;
			m_byte_q <= '0;
			m_end_q <= 1'b0;
			m_last_q <= 1'b0;
		end else begin
			if (pop_ready) begin
				hold_valid_q <= pop_valid;
				hold_q <= pop_entry;
				esc_done_q <= 1'b0;
			end else if (emit) begin
				esc_done_q <= 1'b1;
			end
			if (emit) begin
				m_valid_q <= 1'b1;
				m_byte_q <= need_esc ? cfg.escape : hold_q.data;
				m_end_q <= need_esc ? 1'b0 : hold_q.frame_end;
				m_last_q <= need_esc ? 1'b0 : hold_q.run_last;
			end else if (out_ready) begin
				m_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = m_valid_q;
	assign out_byte  = m_byte_q;
	assign out_end   = m_end_q;
	assign out_last  = m_last_q;

endmodule

/* rtl/core/crcf_checker.sv */
// port-level checks of the crc16 byte stuffing framer, bound to the top level
// depends on crcf_pkg and crc16_byte_stuffing_framer_macros.svh
`include "crc16_byte_stuffing_framer_macros.svh"

module crcf_checker import crcf_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [7:0]  m_axis_tdata,
	input logic        m_axis_tuser,
	input logic        m_axis_tlast,
	input logic        cfg_valid,
	input logic        cfg_ready,
	input logic [1:0]  cfg_index,
	input logic [7:0]  cfg_data
);

	// flag value as seen on the config port
	logic [7:0] flag_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flag_q <= FLAG_RESET;
		end else if (cfg_valid && cfg_ready && cfg_index == CFG_FLAG) begin
			flag_q <= cfg_data;
		end
	end

	// the closing flag always ends the bytes of its input transfer
	`CRCF_ASSERT_IMPL(a_end_is_last, m_axis_tvalid && m_axis_tuser, m_axis_tlast)

	// the closing byte carries the configured flag
	`CRCF_ASSERT_IMPL(a_end_is_flag, m_axis_tvalid && m_axis_tuser, m_axis_tdata == flag_q)

	// a stalled output byte holds
	`CRCF_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) && $stable(m_axis_tlast))

endmodule

bind crc16_byte_stuffing_framer crcf_checker u_crcf_checker (.*);
